/* sv/mhb34id_pkg.sv */
package mhb34id_pkg;

   localparam int MAC_W       = 48;
   localparam int HASH_W      = 64;
   localparam int POS_W       = 4;
   localparam int CHAR_W      = 7;
   localparam int DIG_W       = 6;
   localparam int RSP_DATA_W  = 16;
   localparam int NUM_BYTES   = MAC_W / 8;

   // long division by 34, one 16-bit chunk per cell, top chunk first
   localparam int CHUNK_W     = 16;
   localparam int NUM_CHUNKS  = HASH_W / CHUNK_W;
   localparam int PART_W      = DIG_W + CHUNK_W;
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 28;
   localparam int PROD_W      = PART_W + RECIP_W;

   // ceil(2^28 / 34): exact quotient for any partial dividend below 2^22
   localparam logic [RECIP_W-1:0] RECIP   = 23'd7895161;
   localparam logic [DIG_W-1:0]   RADIX_D = 6'd34;

   localparam logic [HASH_W-1:0] HASH_BASIS = 64'hcbf29ce484222325;

   typedef struct packed {
      logic              valid;
      logic [MAC_W-1:0]  mac;
      logic [HASH_W-1:0] hash;
   } hst_type;

   typedef struct packed {
      logic              valid;
      logic [POS_W-1:0]  pos;
      logic [DIG_W-1:0]  rem;
      logic [HASH_W-1:0] hash;
   } tok_type;

   // x * 0x100000001b3 mod 2^64 as shifts and adds
   function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   // digits, then letters without I and O
   function automatic logic [CHAR_W-1:0] sym_char(input logic [DIG_W-1:0] d);
      logic [CHAR_W-1:0] c;
      c = 7'h30;
      if (d < 6'd10) begin
         c = 7'h30 + CHAR_W'(d);
      end else if (d < 6'd18) begin
         c = 7'h41 + CHAR_W'(d - 6'd10);
      end else if (d < 6'd23) begin
         c = 7'h4A + CHAR_W'(d - 6'd18);
      end else if (d < 6'd34) begin
         c = 7'h50 + CHAR_W'(d - 6'd23);
      end
      return c;
   endfunction

endpackage

/* sv/mac_hash_base34_id_core.sv */
// Path: an accepted MAC runs through the FNV-1a rounds, the digit sequencer, the
//   divider cells and the output register, and leaves rsp as characters in order.
// Sequencing: a new MAC is taken only while the digit sequencer is idle or on its last
//   digit; it issues one base-34 digit per cycle, unless rsp stalls, into the four-cell divider wavefront.
// Reset: synchronous, active high; clears all valid bits and the sequencer.
module mac_hash_base34_id_core #(
   parameter int ID_DIGITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [47:0] mac_address
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // rsp_tdata: [6:0] id_char, [10:7] char_position, [15:11] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast        // last_char
);
   import mhb34id_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(ID_DIGITS - 1);

   // Divider and output register move on one enable, the hash rounds only when the
   // sequencer can also take; the output register frees a slot whenever it is empty or being drained.
   logic advance;
   logic hash_adv;

   // ---- FNV-1a: one byte round per stage, first byte in the first stage ----
   hst_type hst [0:NUM_BYTES];

   assign hst[0] = '{valid: req_tvalid, mac: req_tdata[MAC_W-1:0], hash: HASH_BASIS};

   for (genvar b = 0; b < NUM_BYTES; b++) begin : g_round
      mhb34id_hash_round #(.BYTE_IDX(b)) u_round (
         .clock    (clock),
         .reset    (reset),
         .enable   (hash_adv),
         .up_stage (hst[b]),
         .dn_stage (hst[b+1])
      );
   end

   // ---- digit sequencer: holds one hash, emits ID_DIGITS digit tokens ----
   logic              seq_busy_ff;
   logic [POS_W-1:0]  seq_pos_ff;
   logic [HASH_W-1:0] seq_hash_ff;
   logic              seq_last;
   logic              seq_take;

   assign seq_last = (seq_pos_ff == LAST_POS);
   assign seq_take = !seq_busy_ff || seq_last;
   assign advance  = !rsp_tvalid || rsp_tready;
   // hash pipe moves only when the sequencer can take its head
   assign hash_adv = advance && seq_take;
   assign req_tready = hash_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_busy_ff <= 1'b0;
         seq_pos_ff  <= '0;
      end else if (advance) begin
         if (seq_take) begin
            seq_busy_ff <= hst[NUM_BYTES].valid;
            seq_pos_ff  <= '0;
            seq_hash_ff <= hst[NUM_BYTES].hash;
         end else begin
            seq_pos_ff  <= seq_pos_ff + 1'b1;
         end
      end
   end

   // ---- divide by 34: skewed wavefront, each cell owns one 16-bit chunk ----
   // Cell k works on digit t-k; remainder ripples down, quotient stays put.
   tok_type tok [0:NUM_CHUNKS];

   assign tok[0] = '{valid: seq_busy_ff, pos: seq_pos_ff, rem: '0, hash: seq_hash_ff};

   for (genvar k = 0; k < NUM_CHUNKS; k++) begin : g_cell
      mhb34id_div_cell #(.CHUNK_IDX(k)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (advance),
         .up_tok (tok[k]),
         .dn_tok (tok[k+1])
      );
   end

   // ---- output register: symbol lookup and last flag ----
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic              rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tok[NUM_CHUNKS].valid;
         rsp_char_ff  <= sym_char(tok[NUM_CHUNKS].rem);
         rsp_pos_ff   <= tok[NUM_CHUNKS].pos;
         rsp_last_ff  <= (tok[NUM_CHUNKS].pos == LAST_POS);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-POS_W-CHAR_W){1'b0}}, rsp_pos_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ---- checks ----
   a_take_only_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!seq_busy_ff || seq_last))
      else $error("request taken while sequencer mid-transaction");

   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (advance && seq_busy_ff && !seq_last) |=>
         (seq_busy_ff && seq_pos_ff == $past(seq_pos_ff) + 1'b1))
      else $error("digit position skipped or repeated");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[10:7] == LAST_POS))
      else $error("last flag on wrong character position");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !seq_busy_ff))
      else $error("output or sequencer active after reset");

endmodule

/* sv/mhb34id_hash_round.sv */
module mhb34id_hash_round #(
   parameter int BYTE_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  mhb34id_pkg::hst_type  up_stage,
   output mhb34id_pkg::hst_type  dn_stage
);
   import mhb34id_pkg::*;

   localparam int BYTE_LSB = MAC_W - 8 * (BYTE_IDX + 1);

   logic [HASH_W-1:0] mixed;
   hst_type           rnd_ff, rnd_in;

   assign mixed = up_stage.hash ^ {{(HASH_W-8){1'b0}}, up_stage.mac[BYTE_LSB +: 8]};

   always_comb begin
      rnd_in       = up_stage;
      rnd_in.hash  = fnv_mul(mixed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff.valid <= 1'b0;
      end else if (enable) begin
         rnd_ff <= rnd_in;
      end
   end

   assign dn_stage = rnd_ff;

endmodule

/* sv/mhb34id_div_cell.sv */
module mhb34id_div_cell #(
   parameter int CHUNK_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  mhb34id_pkg::tok_type  up_tok,
   output mhb34id_pkg::tok_type  dn_tok
);
   import mhb34id_pkg::*;

   localparam int CHUNK_LSB = HASH_W - CHUNK_W * (CHUNK_IDX + 1);

   logic [CHUNK_W-1:0] quo_ff, quo_in, dividend;
   logic [PART_W-1:0]  part;
   logic [PROD_W-1:0]  prod;
   logic [DIG_W-1:0]   rem;
   tok_type            tok_ff, tok_in;

   // first digit divides the fresh hash, later ones this cell's last quotient
   assign dividend = (up_tok.pos == '0) ? up_tok.hash[CHUNK_LSB +: CHUNK_W] : quo_ff;
   assign part     = {up_tok.rem, dividend};
   assign prod     = PROD_W'(part) * PROD_W'(RECIP);
   assign quo_in   = prod[RECIP_SHIFT +: CHUNK_W];
   // remainder < 34, so six bits of the difference suffice
   assign rem      = part[DIG_W-1:0] - DIG_W'(quo_in[DIG_W-1:0] * RADIX_D);

   always_comb begin
      tok_in     = up_tok;
      tok_in.rem = rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (enable) begin
         tok_ff <= tok_in;
         if (up_tok.valid) begin
            quo_ff <= quo_in;
         end
      end
   end

   assign dn_tok = tok_ff;

endmodule
